// ===== rtl/imh_pkg.sv =====
// Package for the indexed min-heap: word types, opcodes, status codes
// and controller states. No dependencies.
package imh_pkg;

    typedef enum logic [2:0] {
        OP_QUERY    = 3'd0,
        OP_INSERT   = 3'd1,
        OP_DEL_MIN  = 3'd2,
        OP_CHANGE   = 3'd3,
        OP_DECREASE = 3'd4,
        OP_INCREASE = 3'd5,
        OP_DEL_ID   = 3'd6,
        OP_BAD      = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_BAD_OP  = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [7:0]         item_id;
        logic signed [31:0] new_key;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         removed_id;
        logic [7:0]         min_id;
        logic signed [31:0] min_key;
        logic [8:0]         count;
        logic               is_empty;
        logic               id_present;
        logic signed [31:0] id_key;
    } out_word_t;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_POS, S_DECIDE,
        S_DM_RD, S_DM_WR,
        S_DI_RD, S_DI_WR,
        S_KEY_WR,
        S_UP_RD, S_UP_KEY, S_UP_CMP,
        S_DN_RD, S_DN_KEY, S_DN_KEY2, S_DN_CMP,
        S_SWAP,
        S_CLR_POS,
        S_RPT_RD, S_RPT_KEY, S_RPT_OUT, S_HOLD
    } state_t;

    // Controller to datapath command.
    typedef struct packed {
        logic load_in;
        logic rd_pos;       // read id_position[item_id]
        logic ins_write;    // append id at count+1
        logic dm_read;      // read heap slot 1 and slot count
        logic dm_write;     // move last into slot 1, drop count
        logic di_read;      // read slot count (last)
        logic di_write;     // move last into p, drop count
        logic key_write;
        logic up_read;      // read ids at k and k/2
        logic dn_read;      // read ids at k and 2k
        logic dn_read_r;    // read id at 2k+1
        logic key_read;     // read keys of the ids at k and partner
        logic key_read_r;   // read key of the id at 2k+1
        logic up_cmp;
        logic dn_cmp;
        logic swap;
        logic clr_pos;
        logic rpt_read;
        logic rpt_key;
        logic rpt_out;
        logic set_status;
        logic [2:0] status;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [2:0] opcode;
        logic       present;
        logic       full;
        logic       empty;
        logic       last_slot;  // deleted id sits in the last slot
        logic       move;       // last compare asks for an exchange
        logic       up_done;    // k reached the root
        logic       dn_done;    // no child of k
    } sts_t;

endpackage

// ===== rtl/imh_ctrl.sv =====
// Controller state machine of the indexed min-heap.
// Depends on imh_pkg.
module imh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output imh_pkg::cmd_t   cmd,
    input  imh_pkg::sts_t   sts
);
    import imh_pkg::*;

    state_t state_reg, state_next;
    logic   up_phase_reg, up_phase_next;   // key change: up then down

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            up_phase_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            up_phase_reg <= up_phase_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        up_phase_next = up_phase_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_RD_POS;
            S_RD_POS: state_next = S_DECIDE;
            S_DECIDE: begin
                state_next = S_RPT_RD;
                case (sts.opcode)
                    OP_INSERT: if (!sts.present && !sts.full) state_next = S_UP_RD;
                    OP_DEL_MIN: if (!sts.empty) state_next = S_DM_RD;
                    OP_CHANGE, OP_DECREASE, OP_INCREASE: if (sts.present) begin
                        state_next    = S_KEY_WR;
                        up_phase_next = 1'b1;
                    end
                    OP_DEL_ID: if (sts.present) state_next = S_DI_RD;
                    default: state_next = S_RPT_RD;
                endcase
            end
            S_KEY_WR: state_next = S_UP_RD;
            S_DM_RD:  state_next = S_DM_WR;
            S_DM_WR:  state_next = S_DN_RD;
            S_DI_RD:  state_next = S_DI_WR;
            S_DI_WR: begin
                if (sts.last_slot) state_next = S_CLR_POS;
                else begin
                    state_next    = S_UP_RD;
                    up_phase_next = 1'b1;
                end
            end
            S_UP_RD:  state_next = sts.up_done ? S_UP_CMP : S_UP_KEY;
            S_UP_KEY: state_next = S_UP_CMP;
            S_UP_CMP: begin
                if (!sts.up_done && sts.move) state_next = S_SWAP;
                else if (up_phase_reg) begin
                    up_phase_next = 1'b0;
                    state_next    = S_DN_RD;
                end else state_next = S_RPT_RD;
            end
            S_DN_RD:   state_next = S_DN_KEY;
            S_DN_KEY:  state_next = S_DN_KEY2;
            S_DN_KEY2: state_next = S_DN_CMP;
            S_DN_CMP: begin
                if (!sts.dn_done && sts.move) state_next = S_SWAP;
                else if (sts.opcode inside {OP_DEL_MIN, OP_DEL_ID})
                    state_next = S_CLR_POS;
                else state_next = S_RPT_RD;
            end
            S_SWAP:    state_next = up_phase_reg || sts.opcode == OP_INSERT ?
                                    S_UP_RD : S_DN_RD;
            S_CLR_POS: state_next = S_RPT_RD;
            S_RPT_RD:  state_next = S_RPT_KEY;
            S_RPT_KEY: state_next = S_RPT_OUT;
            S_RPT_OUT: state_next = S_HOLD;
            S_HOLD:    if (m_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_RD_POS: cmd.rd_pos = 1'b1;
            S_DECIDE: begin
                cmd.set_status = 1'b1;
                case (sts.opcode)
                    OP_QUERY: cmd.status = ST_OK;
                    OP_INSERT: begin
                        if (sts.present || sts.full) cmd.status = ST_FULL;
                        else cmd.ins_write = 1'b1;
                    end
                    OP_DEL_MIN: if (sts.empty) cmd.status = ST_EMPTY;
                    OP_CHANGE, OP_DECREASE, OP_INCREASE, OP_DEL_ID:
                        if (!sts.present) cmd.status = ST_ABSENT;
                    default: cmd.status = ST_BAD_OP;
                endcase
            end
            S_KEY_WR:  cmd.key_write = 1'b1;
            S_DM_RD:   cmd.dm_read = 1'b1;
            S_DM_WR:   cmd.dm_write = 1'b1;
            S_DI_RD:   cmd.di_read = 1'b1;
            S_DI_WR:   cmd.di_write = 1'b1;
            S_UP_RD:   cmd.up_read = 1'b1;
            S_UP_KEY:  cmd.key_read = 1'b1;
            S_UP_CMP:  cmd.up_cmp = 1'b1;
            S_DN_RD:   cmd.dn_read = 1'b1;
            S_DN_KEY: begin
                cmd.key_read  = 1'b1;
                cmd.dn_read_r = 1'b1;
            end
            S_DN_KEY2: cmd.key_read_r = 1'b1;
            S_DN_CMP:  cmd.dn_cmp = 1'b1;
            S_SWAP:    cmd.swap = 1'b1;
            S_CLR_POS: cmd.clr_pos = 1'b1;
            S_RPT_RD:  cmd.rpt_read = 1'b1;
            S_RPT_KEY: cmd.rpt_key = 1'b1;
            S_RPT_OUT: cmd.rpt_out = 1'b1;
            S_HOLD:    m_valid = 1'b1;
            default: ;
        endcase
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and result both open");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_RD_POS) else $error("word lost");

endmodule

// ===== rtl/imh_dp.sv =====
// Datapath of the indexed min-heap: heap slot, position and key memories
// plus the sift registers. Depends on imh_pkg.
module imh_dp #(
    parameter int CAPACITY = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  imh_pkg::in_word_t   s_word,
    input  imh_pkg::cmd_t       cmd,
    output imh_pkg::sts_t       sts,
    output imh_pkg::out_word_t  m_word
);
    import imh_pkg::*;

    localparam int LIMIT = (CAPACITY < 256) ? CAPACITY : 256;
    localparam logic [8:0] LIMIT_C = 9'(LIMIT);

    // Slots 1..256 are held at addresses 0..255 (slot-1).
    logic [7:0]  heap_mem [256];
    logic [8:0]  pos_mem  [256];
    logic [31:0] key_mem  [256];
    logic [255:0] pos_valid_reg;   // position entry written since reset

    logic [2:0]  op_reg;
    logic [7:0]  id_reg;
    logic [31:0] key_reg;
    logic [8:0]  count_reg;
    logic [8:0]  pos_reg;      // position of item_id
    logic [8:0]  k_reg;        // current sift slot
    logic [8:0]  c_reg;        // chosen partner slot
    logic [7:0]  ida_reg, idb_reg, idc_reg;   // ids at k, partner, second child
    logic [31:0] ka_reg, kb_reg, kc_reg;
    logic [2:0]  status_reg;
    logic [7:0]  removed_reg;
    logic [7:0]  rd_min_id_reg;
    logic        rd_pres_reg;
    logic [31:0] rd_idkey_reg, rd_minkey_reg;
    out_word_t   out_reg;

    function automatic logic [7:0] sa(input logic [8:0] s);
        return 8'(s - 9'd1);
    endfunction

    wire [8:0] half   = {1'b0, k_reg[8:1]};
    wire [9:0] left   = {k_reg, 1'b0};
    wire [9:0] right  = {k_reg, 1'b1};

    // Memory reads land in registers, at most two addresses of one memory
    // per cycle; an exchange writes two slots at once.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= s_word.opcode;
            id_reg  <= s_word.item_id;
            key_reg <= s_word.new_key;
        end
        if (cmd.rd_pos) pos_reg <= pos_valid_reg[id_reg] ? pos_mem[id_reg] : 9'd0;
        if (cmd.set_status) begin
            status_reg  <= cmd.status;
            removed_reg <= '0;
        end
        if (cmd.ins_write) begin
            heap_mem[sa(count_reg + 9'd1)] <= id_reg;
            pos_mem[id_reg] <= count_reg + 9'd1;
            key_mem[id_reg] <= key_reg;
            k_reg           <= count_reg + 9'd1;
        end
        if (cmd.key_write) begin
            key_mem[id_reg] <= key_reg;
            k_reg           <= pos_reg;
        end
        if (cmd.dm_read) begin
            ida_reg <= heap_mem[8'd0];
            idb_reg <= heap_mem[sa(count_reg)];
        end
        if (cmd.dm_write) begin
            removed_reg      <= ida_reg;
            heap_mem[8'd0]   <= idb_reg;
            pos_mem[idb_reg] <= 9'd1;
            k_reg            <= 9'd1;
        end
        if (cmd.di_read) idb_reg <= heap_mem[sa(count_reg)];
        if (cmd.di_write) begin
            heap_mem[sa(pos_reg)] <= idb_reg;
            pos_mem[idb_reg]      <= pos_reg;
            k_reg                 <= pos_reg;
        end
        if (cmd.up_read) begin
            ida_reg <= heap_mem[sa(k_reg)];
            idb_reg <= heap_mem[sa(half)];
            c_reg   <= half;
        end
        if (cmd.dn_read) begin
            ida_reg <= heap_mem[sa(k_reg)];
            idb_reg <= heap_mem[8'(left - 10'd1)];
        end
        if (cmd.dn_read_r) idc_reg <= heap_mem[8'(right - 10'd1)];
        if (cmd.key_read) begin
            ka_reg <= key_mem[ida_reg];
            kb_reg <= key_mem[idb_reg];
        end
        if (cmd.key_read_r) kc_reg <= key_mem[idc_reg];
        if (cmd.dn_cmp) begin
            if (right <= {1'b0, count_reg} && $signed(kb_reg) > $signed(kc_reg)) begin
                idb_reg  <= idc_reg;
                c_reg    <= 9'(right);
            end else begin
                c_reg    <= 9'(left);
            end
        end
        if (cmd.swap) begin
            heap_mem[sa(k_reg)] <= idb_reg;
            heap_mem[sa(c_reg)] <= ida_reg;
            pos_mem[idb_reg]    <= k_reg;
            pos_mem[ida_reg]    <= c_reg;
            k_reg               <= c_reg;
        end
        if (cmd.clr_pos) pos_mem[(op_reg == OP_DEL_MIN) ? removed_reg : id_reg] <= 9'd0;
        if (cmd.rpt_read) begin
            rd_min_id_reg <= heap_mem[8'd0];
            rd_pres_reg   <= pos_valid_reg[id_reg] && pos_mem[id_reg] != 9'd0;
        end
        if (cmd.rpt_key) begin
            rd_minkey_reg <= key_mem[rd_min_id_reg];
            rd_idkey_reg  <= key_mem[id_reg];
        end
        if (cmd.rpt_out) begin
            out_reg.status     <= status_reg;
            out_reg.removed_id <= removed_reg;
            out_reg.min_id     <= (count_reg != 0) ? rd_min_id_reg : 8'd0;
            out_reg.min_key    <= (count_reg != 0) ? rd_minkey_reg : 32'd0;
            out_reg.count      <= count_reg;
            out_reg.is_empty   <= count_reg == 9'd0;
            out_reg.id_present <= rd_pres_reg;
            out_reg.id_key     <= rd_pres_reg ? rd_idkey_reg : 32'd0;
        end
    end

    // Control registers: count and position valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pos_valid_reg <= '0;
        end else begin
            if (cmd.ins_write) begin
                count_reg              <= count_reg + 9'd1;
                pos_valid_reg[id_reg]  <= 1'b1;
            end
            if (cmd.dm_write || cmd.di_write) count_reg <= count_reg - 9'd1;
        end
    end

    // Down is done once slot k has no left child.
    wire dn_reach = left > {1'b0, count_reg};

    always_comb begin
        sts.opcode    = op_reg;
        sts.present   = pos_reg != 9'd0;
        sts.full      = count_reg >= LIMIT_C;
        sts.empty     = count_reg == 9'd0;
        // Count drops only at the end of the move cycle, so compare to it as is.
        sts.last_slot = pos_reg == count_reg;
        sts.move      = cmd.up_cmp ? ($signed(kb_reg) > $signed(ka_reg)) :
                        (right <= {1'b0, count_reg} && $signed(kb_reg) > $signed(kc_reg))
                        ? ($signed(ka_reg) > $signed(kc_reg))
                        : ($signed(ka_reg) > $signed(kb_reg));
        sts.up_done   = k_reg <= 9'd1;
        sts.dn_done   = dn_reach;
    end

    assign m_word = out_reg;

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LIMIT_C) else $error("count beyond capacity");
    a_k: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |-> c_reg != k_reg) else $error("exchange with itself");
    a_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_write |=> count_reg == $past(count_reg) + 9'd1) else $error("count slip");

endmodule

// ===== rtl/indexed_min_priority_queue.sv =====
// Top level of the indexed min-heap: controller plus datapath.
// A word passes through read, decide, any sift and report steps before its result is offered;
// a sift walks one level at a time, up towards the root or down towards the leaves.
// One word in flight: a new word is taken only after the result of the last one is accepted.
// Reset: aresetn synchronous active low; clears state, count and position valid bits.
module indexed_min_priority_queue #(
    parameter int CAPACITY = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  imh_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output imh_pkg::out_word_t  m_data
);
    import imh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each word through read, decide, sift and report steps.
    imh_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .sts
    );

    // Hold the heap memories and the compare registers.
    imh_dp #(.CAPACITY(CAPACITY)) u_dp (
        .aclk, .aresetn, .s_word(s_data), .cmd, .sts, .m_word(m_data)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the indexed min-heap: drives heap operations over
// valid/ready, predicts each result word and checks it. Depends on imh_pkg.
module tb;
    import imh_pkg::*;

    // Scoreboard: a copy of the heap state plus the queue of predicted words.
    class heap_scoreboard;
        logic [7:0]  slot_id [0:256];
        logic [8:0]  pos_of [0:255];
        logic [31:0] key_of [0:255];
        int unsigned held;
        out_word_t   pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 256; i++) begin
                pos_of[i] = '0;
                key_of[i] = '0;
            end
            held = 0;
            errors = 0;
        endfunction

        function bit gt(logic [31:0] a, logic [31:0] b);
            return $signed(a) > $signed(b);
        endfunction

        function logic [31:0] skey(int unsigned s);
            return key_of[slot_id[s]];
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            logic [7:0] t;
            t = slot_id[a];
            slot_id[a] = slot_id[b];
            slot_id[b] = t;
            pos_of[slot_id[a]] = 9'(a);
            pos_of[slot_id[b]] = 9'(b);
        endfunction

        function void bubble_up(int unsigned k);
            while (k > 1 && gt(skey(k / 2), skey(k))) begin
                swap_slots(k, k / 2);
                k = k / 2;
            end
        endfunction

        function void bubble_down(int unsigned k);
            int unsigned c;
            while (2 * k <= held) begin
                c = 2 * k;
                if (c < held && gt(skey(c), skey(c + 1))) c++;
                if (!gt(skey(k), skey(c))) break;
                swap_slots(k, c);
                k = c;
            end
        endfunction

        function bit has(logic [7:0] id);
            return pos_of[id] != 0;
        endfunction

        // Apply one accepted word to the copy and queue the word it yields.
        function void note_input(in_word_t w);
            out_word_t   r;
            opcode_t     op;
            logic [7:0]  id;
            bit          here;
            int unsigned p, last;
            op = opcode_t'(w.opcode);
            id = w.item_id;
            here = has(id);
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_QUERY: ;
                OP_INSERT: begin
                    if (here || held >= 256) r.status = ST_FULL;
                    else begin
                        held++;
                        slot_id[held] = id;
                        pos_of[id] = 9'(held);
                        key_of[id] = w.new_key;
                        bubble_up(held);
                    end
                end
                OP_DEL_MIN: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else begin
                        r.removed_id = slot_id[1];
                        swap_slots(1, held);
                        held--;
                        bubble_down(1);
                        pos_of[r.removed_id] = 0;
                    end
                end
                OP_CHANGE, OP_DECREASE, OP_INCREASE: begin
                    if (!here) r.status = ST_ABSENT;
                    else begin
                        key_of[id] = w.new_key;
                        bubble_up(pos_of[id]);
                        bubble_down(pos_of[id]);
                    end
                end
                OP_DEL_ID: begin
                    if (!here) r.status = ST_ABSENT;
                    else begin
                        p = pos_of[id];
                        last = held;
                        swap_slots(p, last);
                        held--;
                        if (p != last) begin
                            bubble_up(p);
                            bubble_down(pos_of[slot_id[p]]);
                        end
                        pos_of[id] = 0;
                    end
                end
                default: r.status = ST_BAD_OP;
            endcase
            if (held != 0) begin
                r.min_id = slot_id[1];
                r.min_key = skey(1);
            end
            r.count = 9'(held);
            r.is_empty = held == 0;
            r.id_present = has(id);
            r.id_key = has(id) ? key_of[id] : '0;
            pending = {pending, r};
        endfunction

        function void check_result(out_word_t a);
            out_word_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, a.status); errors++;
            end
            if (a.removed_id !== e.removed_id) begin
                $error("removed_id exp %0d got %0d", e.removed_id, a.removed_id); errors++;
            end
            if (a.min_id !== e.min_id) begin
                $error("min_id exp %0d got %0d", e.min_id, a.min_id); errors++;
            end
            if (a.min_key !== e.min_key) begin
                $error("min_key exp %0d got %0d", e.min_key, a.min_key); errors++;
            end
            if (a.count !== e.count) begin
                $error("count exp %0d got %0d", e.count, a.count); errors++;
            end
            if (a.is_empty !== e.is_empty) begin
                $error("is_empty exp %0d got %0d", e.is_empty, a.is_empty); errors++;
            end
            if (a.id_present !== e.id_present) begin
                $error("id_present exp %0d got %0d", e.id_present, a.id_present); errors++;
            end
            if (a.id_key !== e.id_key) begin
                $error("id_key exp %0d got %0d", e.id_key, a.id_key); errors++;
            end
        endfunction
    endclass

    localparam int LIMIT_CYCLES = 1000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    heap_scoreboard sb;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   sent;
    int   checked;
    int   cycles;

    indexed_min_priority_queue u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result side: stall ready at random and check every accepted word.
    initial begin
        m_ready = 1'b0;
        checked = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_result(m_data);
                checked++;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Present one word and hold it until the block takes it; note it on accept.
    // Valid stays high into the next word unless the sender idles first.
    task automatic send_word(input opcode_t op, input logic [7:0] id,
                             input logic [31:0] k);
        in_word_t w;
        w.opcode = op;
        w.item_id = id;
        w.new_key = k;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(w);
        sent++;
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(3))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Pick ids mostly from a small pool so key changes and deletes hit present ids.
    function automatic logic [7:0] rand_id();
        return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(31));
    endfunction

    task automatic random_phase(input int n, input int fill_bias);
        opcode_t op;
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < fill_bias)      op = OP_INSERT;
            else if (r < 60)        op = OP_DEL_MIN;
            else if (r < 70)        op = OP_CHANGE;
            else if (r < 78)        op = OP_DECREASE;
            else if (r < 86)        op = OP_INCREASE;
            else if (r < 94)        op = OP_DEL_ID;
            else if (r < 98)        op = OP_QUERY;
            else                    op = OP_BAD;
            send_word(op, rand_id(), rand_key());
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-heap failures, key extremes, every opcode, last-slot delete.
        send_word(OP_QUERY,    8'd0,   32'd0);
        send_word(OP_DEL_MIN,  8'd0,   32'd0);
        send_word(OP_CHANGE,   8'd5,   32'd1);
        send_word(OP_DEL_ID,   8'd5,   32'd1);
        send_word(OP_INSERT,   8'd255, 32'h7FFF_FFFF);
        send_word(OP_INSERT,   8'd0,   32'h8000_0000);
        send_word(OP_INSERT,   8'd0,   32'd3);
        send_word(OP_INSERT,   8'd7,   32'hFFFF_FFFF);
        send_word(OP_INSERT,   8'd8,   32'd0);
        send_word(OP_DECREASE, 8'd255, 32'h8000_0000);
        send_word(OP_INCREASE, 8'd0,   32'h7FFF_FFFF);
        send_word(OP_DECREASE, 8'd7,   32'd100);
        send_word(OP_INCREASE, 8'd8,   32'hFFFF_FFF0);
        send_word(OP_BAD,      8'd255, 32'hFFFF_FFFF);
        send_word(OP_DEL_ID,   8'd8,   32'd0);
        send_word(OP_DEL_ID,   8'd0,   32'd0);
        send_word(OP_DEL_MIN,  8'd0,   32'd0);
        send_word(OP_DEL_MIN,  8'd0,   32'd0);
        send_word(OP_DEL_MIN,  8'd0,   32'd0);
        send_word(OP_DEL_MIN,  8'd0,   32'd0);

        // Fill to capacity, hit the full case, then empty the heap again.
        for (int i = 0; i < 256; i++) send_word(OP_INSERT, 8'(i), $urandom);
        send_word(OP_INSERT, 8'd3, 32'd1);
        for (int i = 0; i < 20; i++) send_word(OP_CHANGE, 8'($urandom), rand_key());
        for (int i = 0; i < 256; i++) send_word(OP_DEL_MIN, 8'd0, 32'd0);

        send_idle_pct = 28; recv_idle_pct = 81;
        random_phase(350, 45);
        send_idle_pct = 81; recv_idle_pct = 28;
        random_phase(350, 40);
        send_idle_pct = 0;  recv_idle_pct = 0;
        random_phase(350, 42);
        s_valid <= 1'b0;
        drain();

        $display("Ran %0d words, %0d results checked: all opcodes, full and empty heap,",
                 sent, checked);
        $display("key extremes, last-slot deletes, under sender and receiver stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/imh_pkg.sv
rtl/imh_ctrl.sv
rtl/imh_dp.sv
rtl/indexed_min_priority_queue.sv
bench/tb.sv
